### hdl/miller_rabin_prime_test_macros.svh
// assertion macros for the primality tester
`ifndef MILLER_RABIN_PRIME_TEST_MACROS_SVH
`define MILLER_RABIN_PRIME_TEST_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define MR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/mrpt_pkg.sv
`default_nettype none
package mrpt_pkg;
	localparam int unsigned CfgW = 7;
	localparam int unsigned InW = 32;
	localparam logic [CfgW-1:0] DefaultRounds = 7'd5;
	localparam logic [CfgW-1:0] MaxRounds = 7'd64;

	typedef struct packed {
		logic [InW-1:0] candidate;
		logic [InW-1:0] random_word;
	} mrpt_in_t;

	typedef struct packed {
		logic witness_passed;
		logic test_done;
		logic probable_prime;
	} mrpt_out_t;

	// modular unit commands
	typedef enum logic [1:0] {
		OP_MUL = 2'd0,
		OP_MOD = 2'd1
	} mrpt_op_t;
endpackage
`default_nettype wire

### hdl/mrpt_in_if.sv
`default_nettype none
interface mrpt_in_if;
	logic valid;
	logic ready;
	mrpt_pkg::mrpt_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/mrpt_out_if.sv
`default_nettype none
interface mrpt_out_if;
	logic valid;
	logic ready;
	mrpt_pkg::mrpt_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/mrpt_modmul.sv
`default_nettype none
// bit-serial modular unit: OP_MUL gives (a*b) mod n, OP_MOD gives a mod n
// one bit of b (or a) per cycle, msb first, values stay below 2n
module mrpt_modmul #(
	parameter int unsigned WIDTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire mrpt_pkg::mrpt_op_t op,
	input  wire logic [WIDTH-1:0] a,
	input  wire logic [WIDTH-1:0] b,
	input  wire logic [WIDTH-1:0] n,
	output logic                  done,
	output logic [WIDTH-1:0]      res
);
	import mrpt_pkg::*;
	localparam int unsigned CW = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] acc_q, am_q, n_q, sh_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, mul_q;
	logic [WIDTH+1:0] dbl, addv, sub1;
	logic [WIDTH:0] red1;
	logic [WIDTH-1:0] nxt;

	// acc = 2*acc + bit, reduced, or 2*acc (+a), reduced
	always_comb begin
		dbl = {1'b0, acc_q, 1'b0};
		if (mul_q) begin
			dbl = dbl - ((dbl >= {2'b0, n_q}) ? {2'b0, n_q} : '0);
			addv = dbl + (sh_q[WIDTH-1] ? {2'b0, am_q} : '0);
		end else begin
			addv = dbl + {{(WIDTH+1){1'b0}}, sh_q[WIDTH-1]};
		end
		sub1 = addv - ((addv >= {2'b0, n_q}) ? {2'b0, n_q} : '0);
		red1 = sub1[WIDTH:0];
		nxt = red1[WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			n_q <= n;
			mul_q <= (op == OP_MUL);
			am_q <= a;
			sh_q <= (op == OP_MUL) ? b : a;
		end else if (busy_q) begin
			acc_q <= nxt;
			sh_q <= {sh_q[WIDTH-2:0], 1'b0};
		end
	end
	assign res = acc_q;
endmodule
`default_nettype wire

### hdl/miller_rabin_prime_test.sv
// each round runs up to 2*WIDTH-2 modular products on the bit-serial unit;
// rejected candidates and the candidate 2 skip the unit and go straight to the result
// throughput: one transaction at a time, set by the single bit-serial modular unit
// the result register lets the next transaction be taken while a result waits
// reset: arst_n asynchronous active low, clears control state and sets rounds to 5
`default_nettype none
`include "miller_rabin_prime_test_macros.svh"
module miller_rabin_prime_test #(
	parameter int unsigned WIDTH = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [mrpt_pkg::CfgW-1:0] cfg_wdata,
	mrpt_in_if.sink                      in_ch,
	mrpt_out_if.source                   out_ch
);
	import mrpt_pkg::*;
	localparam int unsigned EW = $clog2(WIDTH + 1);

	// sequencer states
	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_MODR  = 8'b0000_0010,
		ST_STRIP = 8'b0000_0100,
		ST_PMUL  = 8'b0000_1000,
		ST_PSQ   = 8'b0001_0000,
		ST_CHK   = 8'b0010_0000,
		ST_SQ    = 8'b0100_0000,
		ST_FIN   = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [CfgW-1:0] rounds_q;
	logic [5:0] round_count_q;
	logic [WIDTH-1:0] n_q, nm1_q, d_q, acc_q, sq_q, rnd_q;
	logic [EW-1:0] s_q;
	logic [31:0] rndw_q;
	logic [5:0] rbits_q;
	logic pass_q, wait_q;
	logic out_valid_q;
	mrpt_out_t out_q;

	// modular unit interface
	logic mm_start, mm_done;
	mrpt_op_t mm_op;
	logic [WIDTH-1:0] mm_a, mm_b, mm_n, mm_res;

	mrpt_modmul #(.WIDTH(WIDTH)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mm_start), .op(mm_op),
		.a(mm_a), .b(mm_b), .n(mm_n), .done(mm_done), .res(mm_res)
	);

	logic [CfgW-1:0] need;
	logic [WIDTH-1:0] cand;
	logic reject, take;
	always_comb begin
		need = rounds_q;
		if (need == '0) need = CfgW'(1);
		if (need > MaxRounds) need = MaxRounds;
		cand = in_ch.data.candidate[WIDTH-1:0];
		reject = (cand < WIDTH'(2)) || (cand != WIDTH'(2) && !cand[0]);
	end

	// a waiting result does not block input, the finish state holds until it drains
	assign in_ch.ready = (state_q == ST_IDLE);
	assign take = in_ch.valid && in_ch.ready;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;

	// random word mod (n-1): fold the 32-bit word in locally, not through the unit,
	// msb first: r = (2*r + bit) mod (n-1), done bit-serially
	// here via a shift register of the word one bit per cycle
	logic [WIDTH:0] rdbl;
	logic [WIDTH:0] rsub;
	always_comb begin
		rdbl = {rnd_q, rndw_q[31]};
		rsub = rdbl - ((rdbl >= {1'b0, nm1_q}) ? {1'b0, nm1_q} : '0);
	end

	always_comb begin
		mm_start = 1'b0;
		mm_op = OP_MUL;
		mm_a = sq_q;
		mm_b = sq_q;
		mm_n = n_q;
		if (!wait_q) begin
			unique case (state_q)
				ST_PMUL: begin
					mm_start = d_q[0];
					mm_a = acc_q;
				end
				ST_PSQ: mm_start = 1'b1;
				ST_SQ: mm_start = 1'b1;
				default: mm_start = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rounds_q <= DefaultRounds;
			round_count_q <= '0;
			out_valid_q <= 1'b0;
			wait_q <= 1'b0;
			n_q <= '0;
			nm1_q <= '0;
			d_q <= '0;
			acc_q <= '0;
			sq_q <= '0;
			rnd_q <= '0;
			s_q <= '0;
			rndw_q <= '0;
			rbits_q <= '0;
			pass_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (cfg_we) rounds_q <= cfg_wdata;
			// the finish state reloads the result register itself
			if (out_valid_q && out_ch.ready && state_q != ST_FIN) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						// payload captured at the accepted transaction
						n_q <= cand;
						nm1_q <= cand - WIDTH'(1);
						d_q <= cand - WIDTH'(1);
						s_q <= '0;
						rnd_q <= '0;
						rndw_q <= in_ch.data.random_word;
						rbits_q <= 6'd32;
						if (reject) begin
							pass_q <= 1'b0;
							state_q <= ST_FIN;
						end else if (cand == WIDTH'(2)) begin
							pass_q <= 1'b1;
							state_q <= ST_FIN;
						end else state_q <= ST_MODR;
					end
				end
				ST_MODR: begin
					// one bit of the random word per cycle, remainder kept below n-1
					rnd_q <= rsub[WIDTH-1:0];
					rndw_q <= {rndw_q[30:0], 1'b0};
					rbits_q <= rbits_q - 1'b1;
					if (rbits_q == 6'd1) state_q <= ST_STRIP;
				end
				ST_STRIP: begin
					// strip factors of two, one per cycle
					if (!d_q[0]) begin
						d_q <= d_q >> 1;
						s_q <= s_q + 1'b1;
					end else begin
						sq_q <= rnd_q + WIDTH'(1);
						acc_q <= WIDTH'(1);
						state_q <= ST_PMUL;
					end
				end
				ST_PMUL: begin
					if (!wait_q) begin
						if (d_q == '0) state_q <= ST_CHK;
						else if (d_q[0]) wait_q <= 1'b1;
						else state_q <= ST_PSQ;
					end else if (mm_done) begin
						acc_q <= mm_res;
						wait_q <= 1'b0;
						state_q <= ST_PSQ;
					end
				end
				ST_PSQ: begin
					if (!wait_q) wait_q <= 1'b1;
					else if (mm_done) begin
						sq_q <= mm_res;
						d_q <= d_q >> 1;
						wait_q <= 1'b0;
						state_q <= ST_PMUL;
					end
				end
				ST_CHK: begin
					sq_q <= acc_q;
					if (acc_q == WIDTH'(1) || acc_q == nm1_q) begin
						pass_q <= 1'b1;
						state_q <= ST_FIN;
					end else if (s_q <= EW'(1)) begin
						pass_q <= 1'b0;
						state_q <= ST_FIN;
					end else begin
						s_q <= s_q - 1'b1;
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (!wait_q) wait_q <= 1'b1;
					else if (mm_done) begin
						wait_q <= 1'b0;
						sq_q <= mm_res;
						if (mm_res == nm1_q) begin
							pass_q <= 1'b1;
							state_q <= ST_FIN;
						end else if (mm_res == WIDTH'(1) || s_q == EW'(1)) begin
							pass_q <= 1'b0;
							state_q <= ST_FIN;
						end else s_q <= s_q - 1'b1;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						if (!pass_q) begin
							round_count_q <= '0;
							out_q <= '{witness_passed: 1'b0, test_done: 1'b1,
								probable_prime: 1'b0};
						end else if ({1'b0, round_count_q} + 7'd1 >= need) begin
							round_count_q <= '0;
							out_q <= '{witness_passed: 1'b1, test_done: 1'b1,
								probable_prime: 1'b1};
						end else begin
							round_count_q <= round_count_q + 1'b1;
							out_q <= '{witness_passed: 1'b1, test_done: 1'b0,
								probable_prime: 1'b0};
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`MR_ASSERT_IMPL(a_ready_idle, clk, arst_n, in_ch.ready, state_q == ST_IDLE)
	`MR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
	`MR_ASSERT_IMPL(a_prime_done, clk, arst_n, out_ch.valid && out_q.probable_prime,
		out_q.test_done && out_q.witness_passed)
	`MR_ASSERT_IMPL(a_wait_busy, clk, arst_n, wait_q,
		state_q == ST_PMUL || state_q == ST_PSQ || state_q == ST_SQ)
endmodule
`default_nettype wire
